@@ hdl/ordered_dither_palette_mapper_unit_defines.svh @@
// ============================================================================
// Assertion macros for the ordered dither palette mapper
// Shared property wrappers used by the checker module.
// ============================================================================
`ifndef ORDERED_DITHER_PALETTE_MAPPER_UNIT_DEFINES_SVH
`define ORDERED_DITHER_PALETTE_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ODPM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ordered dither palette mapper: property violated");

// Next-cycle implication, disabled while reset is high.
`define ODPM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ordered dither palette mapper: property violated");

`endif

@@ hdl/odpm_pkg.sv @@
// ============================================================================
// Ordered dither palette mapper package
// Payload types, register indexes and the two constant lookup tables.
// ============================================================================
package odpm_pkg;

   // Widths of the fixed fields.
   localparam int unsigned LEVEL_W  = 4;
   localparam int unsigned THRESH_W = 6;
   localparam int unsigned CSR_W    = 3;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      CSR_DISPLAY_MODE    = 1'b0,
      CSR_DITHER_STRENGTH = 1'b1
   } csr_index_type;

   localparam logic [THRESH_W-1:0] THRESH_FULL_MASK = 6'h3F;
   localparam logic [2:0]          STRENGTH_RESET   = 3'd6;
   localparam logic [16:0]         BIAS_OFFSET      = 17'd65280;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] column;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic [7:0]  color_index;
      logic [15:0] buffer_offset;
      logic [1:0]  plane_number;
   } rsp_type;

   typedef logic [255:0][15:0] inten_rom_type;
   typedef logic [63:0][15:0]  bias_rom_type;

   // Exact rounding search, run only while the tables are elaborated.
   // Returns the largest v with v - 1/2 not above the exact scaled value.
   function automatic logic [16:0] round_search(input logic kind, input int unsigned arg);
      logic [16:0]  lo;
      logic [16:0]  hi;
      logic [16:0]  mid;
      logic [127:0] t;
      logic [127:0] a;
      logic [127:0] lhs;
      logic [127:0] rhs;
      lo = '0;
      hi = 17'd65536;
      a  = 128'(arg);
      for (int k = 0; k < 18; k++) begin
         if (lo < hi) begin
            mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
            t   = 128'(2 * 128'(mid) - 128'd1);
            if (kind == 1'b0) begin
               lhs = t * t * t * 128'd65025;
               rhs = (128'd1 << 51) * a * a;
            end else begin
               lhs = t * t * t * t;
               rhs = (128'd1 << 50) * a * a * a;
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = 17'(mid - 17'd1);
            end
         end
      end
      return lo;
   endfunction

   // Intensity (i/255)^(2/3) in Q0.16; full intensity saturates to all ones.
   function automatic inten_rom_type build_inten_rom();
      inten_rom_type rom;
      logic [16:0]   v;
      for (int i = 0; i < 256; i++) begin
         v = round_search(1'b0, i);
         rom[i] = (v > 17'h0FFFF) ? 16'hFFFF : v[15:0];
      end
      return rom;
   endfunction

   // Dither bias in Q0.16, indexed by the masked threshold.
   function automatic bias_rom_type build_bias_rom();
      bias_rom_type rom;
      logic [16:0]  v;
      for (int i = 0; i < 64; i++) begin
         v = round_search(1'b1, i);
         rom[i] = 16'(BIAS_OFFSET - v);
      end
      return rom;
   endfunction

   localparam inten_rom_type INTEN_ROM = build_inten_rom();
   localparam bias_rom_type  BIAS_ROM  = build_bias_rom();

   // Threshold bits kept for a given dither strength.
   function automatic logic [THRESH_W-1:0] strength_mask(input logic [2:0] strength);
      return THRESH_FULL_MASK - (THRESH_FULL_MASK >> strength);
   endfunction

   // Level of one channel: min(L-1, (I*(L-1) + bias) >> 16).
   function automatic logic [LEVEL_W-1:0] channel_level(input logic [15:0] inten,
                                                        input logic [15:0] bias,
                                                        input logic [LEVEL_W-1:0] top);
      logic [20:0] acc;
      logic [4:0]  lvl;
      acc = 21'(inten) * 21'(top) + 21'(bias);
      lvl = acc[20:16];
      return (lvl < 5'(top)) ? lvl[LEVEL_W-1:0] : top;
   endfunction

endpackage

@@ hdl/ordered_dither_palette_mapper_unit.sv @@
// ============================================================================
// Ordered dither palette mapper
// Maps an RGB pixel onto a regular palette with an 8x8 Bayer ordered dither.
// ============================================================================
// A pixel is taken on every cycle in which start is high and busy is low;
// busy is high only while reset is held, so one pixel per clock is accepted.
// Each pixel gives one result: the pixel is registered, passes through the
// table lookups and constant multiplies into the result register, and the
// result stands on rsp for a single cycle marked by rsp_valid. The
// receiver cannot stall, so it must take every result in the cycle shown.
// Configuration writes take effect on pixels accepted at or after the write.
// ============================================================================
module ordered_dither_palette_mapper_unit #(
   parameter int unsigned RED_LEVELS   = 7,
   parameter int unsigned GREEN_LEVELS = 9,
   parameter int unsigned BLUE_LEVELS  = 4,
   parameter int unsigned LINE_WIDTH   = 320
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  odpm_pkg::req_type             req,
   output logic                          rsp_valid,
   output odpm_pkg::rsp_type             rsp,
   input  logic                          csr_write_enable,
   input  odpm_pkg::csr_index_type       csr_index,
   input  logic [odpm_pkg::CSR_W-1:0]    csr_write_data
);
   import odpm_pkg::*;

   localparam logic [LEVEL_W-1:0] RED_TOP   = LEVEL_W'(RED_LEVELS - 1);
   localparam logic [LEVEL_W-1:0] GREEN_TOP = LEVEL_W'(GREEN_LEVELS - 1);
   localparam logic [LEVEL_W-1:0] BLUE_TOP  = LEVEL_W'(BLUE_LEVELS - 1);
   localparam int unsigned        PLANE_WIDTH = LINE_WIDTH / 4;

   logic                display_mode_ff;
   logic [2:0]          dither_strength_ff;
   logic                valid_ff;
   req_type             req_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                accept;
   logic [2:0]          x_bits;
   logic [2:0]          z_bits;
   logic [THRESH_W-1:0] thresh;
   logic [15:0]         bias;
   logic [LEVEL_W-1:0]  red_level;
   logic [LEVEL_W-1:0]  green_level;
   logic [LEVEL_W-1:0]  blue_level;
   logic [15:0]         index_wide;
   logic [19:0]         offset_linear;
   logic [19:0]         offset_planar;
   rsp_type             rsp_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff    <= 1'b0;
         dither_strength_ff <= STRENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DISPLAY_MODE:    display_mode_ff    <= csr_write_data[0];
            CSR_DITHER_STRENGTH: dither_strength_ff <= csr_write_data;
            default:             display_mode_ff    <= display_mode_ff;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   // Bayer threshold from the low coordinate bits, then the masked bias.
   assign x_bits = req_ff.column[2:0];
   assign z_bits = req_ff.column[2:0] ^ req_ff.row[2:0];
   assign thresh = {z_bits[0], x_bits[0], z_bits[1], x_bits[1], z_bits[2], x_bits[2]};
   assign bias   = BIAS_ROM[thresh & strength_mask(dither_strength_ff)];

   // Per-channel quantisation and the palette index.
   assign red_level   = channel_level(INTEN_ROM[req_ff.red],   bias, RED_TOP);
   assign green_level = channel_level(INTEN_ROM[req_ff.green], bias, GREEN_TOP);
   assign blue_level  = channel_level(INTEN_ROM[req_ff.blue],  bias, BLUE_TOP);
   assign index_wide  = 16'(red_level) * 16'(GREEN_LEVELS * BLUE_LEVELS)
                      + 16'(green_level) * 16'(BLUE_LEVELS)
                      + 16'(blue_level);

   // Frame-buffer offset for both display modes.
   assign offset_linear = 20'(req_ff.row) * 20'(LINE_WIDTH) + 20'(req_ff.column);
   assign offset_planar = 20'(req_ff.row) * 20'(PLANE_WIDTH) + 20'(req_ff.column[8:2]);

   always_comb begin
      rsp_in.color_index = index_wide[7:0];
      if (display_mode_ff) begin
         rsp_in.buffer_offset = offset_planar[15:0];
         rsp_in.plane_number  = req_ff.column[1:0];
      end else begin
         rsp_in.buffer_offset = offset_linear[15:0];
         rsp_in.plane_number  = 2'd0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ hdl/odpm_checker.sv @@
// ============================================================================
// Ordered dither palette mapper checker
// Port-level properties on transfer timing and result consistency.
// ============================================================================
`include "ordered_dither_palette_mapper_unit_defines.svh"

module odpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input odpm_pkg::req_type             req,
   input logic                          rsp_valid,
   input odpm_pkg::rsp_type             rsp,
   input logic                          csr_write_enable
);
   import odpm_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // Every accepted pixel is answered through the input and result registers, never otherwise.
   `ODPM_ASSERT_NEXT(a_result_follows, clock, reset, accept, ##1 rsp_valid)
   `ODPM_ASSERT_NEXT(a_no_spurious_result, clock, reset, !accept, ##1 !rsp_valid)

   // Two identical pixels in a row with no register write give identical results.
   `ODPM_ASSERT_NEXT(a_same_pixel_same_result, clock, reset,
      accept && $past(accept) && $stable(req) && !csr_write_enable
      && !$past(csr_write_enable), ##1 $stable(rsp))

   // Outside reset the block is never busy, so it can always take a pixel.
   `ODPM_ASSERT_NOW(a_never_busy, clock, reset, 1'b1, !busy)

endmodule

bind ordered_dither_palette_mapper_unit odpm_checker u_odpm_checker (.*);
